// ===== design/owm_pkg.sv =====
// package for the one-wire bus master: types, constants, phase and operation codes
// used by the front, back and top level
package owm_pkg;

   localparam int ROM_BYTES_DEF = 8;

   localparam logic [9:0] RESET_LOW_DEF     = 10'd600;
   localparam logic [9:0] PRESENCE_WAIT_DEF = 10'd66;
   localparam logic [9:0] RESET_TAIL_DEF    = 10'd414;
   localparam logic [9:0] RELEASE_DEF       = 10'd1;
   localparam logic [9:0] SAMPLE_DEF        = 10'd12;
   localparam logic [9:0] SLOT_DEF          = 10'd60;
   localparam logic [9:0] GAP_DEF           = 10'd10;

   localparam logic [7:0] OW_SEARCH = 8'hF0;
   localparam logic [7:0] OW_MATCH  = 8'h55;
   localparam logic [7:0] OW_SKIP   = 8'hCC;

   localparam logic [2:0] REG_RESET_LOW     = 3'd0;
   localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
   localparam logic [2:0] REG_RELEASE       = 3'd3;
   localparam logic [2:0] REG_SAMPLE        = 3'd4;
   localparam logic [2:0] REG_SLOT          = 3'd5;
   localparam logic [2:0] REG_GAP           = 3'd6;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_PRES = 2'd1;
   localparam logic [1:0] ST_DATA    = 2'd2;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_RESET  = 3'd1,
      CMD_BYTE   = 3'd2,
      CMD_SEARCH = 3'd3,
      CMD_ADDR   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_SLOT, PH_GAP
   } phase_type;

   typedef enum logic [1:0] {
      K_BYTE, K_READ, K_COMP, K_WRITE
   } kind_type;

   typedef struct packed {
      logic [9:0] reset_low;
      logic [9:0] presence_wait;
      logic [9:0] reset_tail;
      logic [9:0] release_t;
      logic [9:0] sample_t;
      logic [9:0] slot_t;
      logic [9:0] gap_t;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic        start;
      logic [2:0]  op;
      logic        line;
      logic [7:0]  data_byte;
      logic [63:0] rom_id;
      logic [6:0]  last_diff;
      logic        use_address;
   } item_type;

   typedef struct packed {
      logic        line_drive;
      logic        busy;
      logic        done;
      logic [1:0]  status;
      logic [7:0]  data_out;
      logic [63:0] rom_id_out;
      logic [6:0]  search_diff;
   } result_type;

   function automatic logic [9:0] at_least_one(input logic [9:0] v);
      return (v == 10'd0) ? 10'd1 : v;
   endfunction

endpackage

// ===== design/owm_front.sv =====
// front end: register file, item capture and classification
// depends on owm_pkg
module owm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [2:0]         req_cmd,
   input  logic               req_line,
   input  logic [7:0]         req_data_byte,
   input  logic [63:0]        req_rom_id,
   input  logic [6:0]         req_last_diff,
   input  logic               req_use_address,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [9:0]         csr_data,
   output owm_pkg::cfg_type   cfg,
   output logic               q_valid,
   input  logic               q_ready,
   output owm_pkg::item_type  q_item
);
   import owm_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign csr_ready  = 1'b1;
   assign req_tready = !valid_ff || q_ready;
   assign cfg        = cfg_ff;
   assign q_valid    = valid_ff;
   assign q_item     = item_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_RESET_LOW:     cfg_in.reset_low     = csr_data;
            REG_PRESENCE_WAIT: cfg_in.presence_wait = csr_data;
            REG_RESET_TAIL:    cfg_in.reset_tail    = csr_data;
            REG_RELEASE:       cfg_in.release_t     = csr_data;
            REG_SAMPLE:        cfg_in.sample_t      = csr_data;
            REG_SLOT:          cfg_in.slot_t        = csr_data;
            REG_GAP:           cfg_in.gap_t         = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (q_ready) valid_in = 1'b0;
      if (req_tvalid && req_tready) begin
         valid_in            = 1'b1;
         item_in.start       = req_cmd inside {CMD_RESET, CMD_BYTE, CMD_SEARCH, CMD_ADDR};
         item_in.op          = req_cmd;
         item_in.line        = req_line;
         item_in.data_byte   = req_data_byte;
         item_in.rom_id      = req_rom_id;
         item_in.last_diff   = req_last_diff;
         item_in.use_address = req_use_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '{RESET_LOW_DEF, PRESENCE_WAIT_DEF, RESET_TAIL_DEF, RELEASE_DEF,
                       SAMPLE_DEF, SLOT_DEF, GAP_DEF};
         valid_ff <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== design/owm_back.sv =====
// back end: bus sequencer for reset, byte, addressed command and rom search,
// with a result register; depends on owm_pkg
module owm_back #(
   parameter int ROM_BYTES = owm_pkg::ROM_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  owm_pkg::cfg_type     cfg,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  owm_pkg::item_type    q_item,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output owm_pkg::result_type  rsp_res
);
   import owm_pkg::*;

   localparam int NBITS = ROM_BYTES * 8;
   localparam logic [6:0] NBITS7 = 7'(NBITS);

   phase_type   phase_ff, phase_in;
   kind_type    kind_ff, kind_in;
   logic [9:0]  tc_ff, tc_in;
   logic [6:0]  pos_ff, pos_in;
   logic [7:0]  bsh_ff, bsh_in;
   logic [63:0] id_ff, id_in;
   logic [6:0]  fd_ff, fd_in, sd_ff, sd_in;
   logic        rb_ff, rb_in, sb_ff, sb_in, smp_ff, smp_in;
   logic [1:0]  err_ff, err_in;
   logic [3:0]  left_ff, left_in;
   logic [2:0]  op_ff, op_in;
   logic [7:0]  hold_ff, hold_in;
   logic        ov_ff, ov_in;
   result_type  res_ff, res_in;

   logic        take;
   logic [9:0]  t, target, slot_end;
   logic [10:0] tsum;
   logic        fin, b, smp_now;
   logic [1:0]  fst;
   logic [63:0] id_mask;

   assign q_ready    = !ov_ff || rsp_tready;
   assign take       = q_valid && q_ready;
   assign rsp_tvalid = ov_ff;
   assign rsp_res    = res_ff;
   assign id_mask    = (NBITS >= 64) ? '1 : ((64'd1 << NBITS) - 64'd1);

   always_comb begin
      phase_in = phase_ff; kind_in = kind_ff; tc_in = tc_ff; pos_in = pos_ff;
      bsh_in = bsh_ff; id_in = id_ff; fd_in = fd_ff; sd_in = sd_ff;
      rb_in = rb_ff; sb_in = sb_ff; smp_in = smp_ff; err_in = err_ff;
      left_in = left_ff; op_in = op_ff; hold_in = hold_ff;
      ov_in = ov_ff; res_in = res_ff;
      fin = 1'b0; fst = ST_OK; b = 1'b0; smp_now = smp_ff;
      t = tc_ff + 10'd1;
      tsum = {1'b0, cfg.release_t} + {1'b0, cfg.sample_t};
      target = (tsum > {1'b0, cfg.slot_t}) ? cfg.slot_t : tsum[9:0];
      target = at_least_one(target);
      slot_end = at_least_one(cfg.slot_t);
      if (rsp_tready) ov_in = 1'b0;
      if (take) begin
         if (phase_ff == PH_IDLE && q_item.start) begin
            op_in = q_item.op; err_in = ST_OK; tc_in = '0;
            if (q_item.op == CMD_BYTE) begin
               bsh_in = q_item.data_byte; pos_in = 7'd8; phase_in = PH_SLOT;
               sb_in = q_item.data_byte[0]; kind_in = K_BYTE; smp_in = 1'b0;
            end else begin
               phase_in = PH_RST_LOW;
               if (q_item.op == CMD_SEARCH) begin
                  id_in = q_item.rom_id; sd_in = q_item.last_diff; fd_in = '0;
               end else if (q_item.op == CMD_ADDR) begin
                  id_in = q_item.rom_id; hold_in = q_item.data_byte;
                  left_in = q_item.use_address ? 4'(ROM_BYTES + 1) : 4'd1;
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            tc_in = t;
            case (phase_ff)
               PH_RST_LOW:
                  if (t >= at_least_one(cfg.reset_low)) begin
                     phase_in = PH_RST_WAIT; tc_in = '0;
                  end
               PH_RST_WAIT:
                  if (t >= at_least_one(cfg.presence_wait)) begin
                     err_in = {1'b0, q_item.line}; phase_in = PH_RST_TAIL; tc_in = '0;
                  end
               PH_RST_TAIL:
                  if (t >= at_least_one(cfg.reset_tail)) begin
                     if (!q_item.line) err_in = ST_NO_PRES;
                     if (op_ff == CMD_RESET) begin
                        fin = 1'b1; fst = err_in;
                     end else if (op_ff == CMD_SEARCH && err_in != ST_OK) begin
                        fin = 1'b1; fst = ST_NO_PRES;
                     end else begin
                        bsh_in = (op_ff == CMD_SEARCH) ? OW_SEARCH :
                                 (left_ff > 4'd1) ? OW_MATCH : OW_SKIP;
                        pos_in = 7'd8; phase_in = PH_SLOT; tc_in = '0;
                        sb_in = bsh_in[0]; kind_in = K_BYTE; smp_in = 1'b0;
                     end
                  end
               PH_SLOT, PH_GAP: begin
                  if (phase_ff == PH_SLOT && t == target) smp_now = sb_ff & q_item.line;
                  smp_in = smp_now;
                  if (phase_ff == PH_SLOT && t >= slot_end && cfg.gap_t != 10'd0) begin
                     phase_in = PH_GAP; tc_in = '0;
                  end else if ((phase_ff == PH_SLOT && t >= slot_end) ||
                               (phase_ff == PH_GAP && t >= cfg.gap_t)) begin
                     // bit slot complete
                     phase_in = PH_SLOT; tc_in = '0; smp_in = 1'b0;
                     case (kind_ff)
                        K_BYTE: begin
                           bsh_in = {smp_now, bsh_ff[7:1]};
                           pos_in = pos_ff - 7'd1;
                           sb_in  = bsh_in[0];
                           if (pos_in == 7'd0) begin
                              if (op_ff == CMD_SEARCH) begin
                                 pos_in = NBITS7; sb_in = 1'b1; kind_in = K_READ;
                              end else if (op_ff == CMD_ADDR && left_ff != 4'd0) begin
                                 if (left_ff > 4'd1) begin
                                    bsh_in = id_ff[7:0]; id_in = id_ff >> 8;
                                    left_in = left_ff - 4'd1;
                                 end else begin
                                    bsh_in = hold_ff; left_in = '0;
                                 end
                                 pos_in = 7'd8; sb_in = bsh_in[0];
                              end else begin
                                 fin = 1'b1;
                                 fst = (op_ff == CMD_ADDR) ? err_ff : ST_OK;
                              end
                           end
                        end
                        K_READ: begin
                           rb_in = smp_now; sb_in = 1'b1; kind_in = K_COMP;
                        end
                        K_COMP: begin
                           b = rb_ff;
                           if (rb_ff && smp_now) begin
                              fin = 1'b1; fst = ST_DATA;
                           end else begin
                              if (!rb_ff && !smp_now &&
                                  (sd_ff > pos_ff || (id_ff[0] && sd_ff != pos_ff))) begin
                                 b = 1'b1; fd_in = pos_ff;
                              end
                              sb_in = b; kind_in = K_WRITE;
                           end
                        end
                        default: begin
                           id_in = ((id_ff >> 1) & (id_mask >> 1)) |
                                   (64'(sb_ff) << (NBITS - 1));
                           pos_in = pos_ff - 7'd1;
                           if (pos_in == 7'd0) begin
                              fin = 1'b1; fst = ST_OK;
                           end else begin
                              sb_in = 1'b1; kind_in = K_READ;
                           end
                        end
                     endcase
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
         if (fin) phase_in = PH_IDLE;
         ov_in = 1'b1;
         res_in.busy = (phase_in != PH_IDLE);
         res_in.done = fin;
         res_in.status = fin ? fst : ST_OK;
         res_in.data_out = (fin && op_ff == CMD_BYTE && fst == ST_OK) ? bsh_in : 8'd0;
         res_in.rom_id_out = (fin && op_ff == CMD_SEARCH && fst == ST_OK) ? id_in : 64'd0;
         res_in.search_diff = (fin && op_ff == CMD_SEARCH && fst == ST_OK) ? fd_in : 7'd0;
         if (phase_in == PH_RST_LOW) res_in.line_drive = 1'b1;
         else if (phase_in == PH_SLOT)
            res_in.line_drive = !(sb_in && tc_in >= cfg.release_t);
         else res_in.line_drive = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; kind_ff <= K_BYTE; tc_ff <= '0; pos_ff <= '0;
         bsh_ff <= '0; id_ff <= '0; fd_ff <= '0; sd_ff <= '0; rb_ff <= 1'b0;
         sb_ff <= 1'b0; smp_ff <= 1'b0; err_ff <= '0; left_ff <= '0;
         op_ff <= '0; hold_ff <= '0; ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; kind_ff <= kind_in; tc_ff <= tc_in; pos_ff <= pos_in;
         bsh_ff <= bsh_in; id_ff <= id_in; fd_ff <= fd_in; sd_ff <= sd_in;
         rb_ff <= rb_in; sb_ff <= sb_in; smp_ff <= smp_in; err_ff <= err_in;
         left_ff <= left_in; op_ff <= op_in; hold_ff <= hold_in; ov_ff <= ov_in;
      end
      res_ff <= res_in;
   end

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_res.done && rsp_res.busy)) else $error("done while busy");
   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_res.busy) |-> !rsp_res.line_drive) else $error("drive when idle");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= NBITS7 || pos_ff <= 7'd8) else $error("bit position out of range");

endmodule

// ===== design/one_wire_bus_master_with_rom_search_top.sv =====
// channel  | dir | tdata fields (low bit up)                          | tuser
// req      | in  | line_in, data_byte, rom_id, last_diff, use_address  | cmd
// rsp      | out | line_drive,busy,done,status,data_out,rom_id_out,diff | -
// csr      | in  | index 3 bits, data 10 bits                           | -
// one item per cycle while the rsp side is not stalled; a result passes through the item
// queue and then the back end's output register.
// synchronous reset restores register defaults and idles the sequencer.
// a stalled rsp side holds both the result register and the item queue.
// depends on owm_pkg, owm_front, owm_back
module one_wire_bus_master_with_rom_search_top #(
   parameter int ROM_BYTES = owm_pkg::ROM_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,  // line_in, data_byte, rom_id, last_diff, use_address
   input  logic [2:0]   req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,  // line_drive, busy, done, status, data_out, rom_id_out,
                                    // search_diff
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [9:0]   csr_data
);
   import owm_pkg::*;

   cfg_type    cfg;
   logic       q_valid, q_ready;
   item_type   q_item;
   result_type res;

   owm_front u_front (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_cmd(req_tuser), .req_line(req_tdata[0]), .req_data_byte(req_tdata[8:1]),
      .req_rom_id(req_tdata[72:9]), .req_last_diff(req_tdata[79:73]),
      .req_use_address(req_tdata[80]),
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .cfg, .q_valid, .q_ready, .q_item
   );

   owm_back #(.ROM_BYTES(ROM_BYTES)) u_back (
      .clock, .reset, .cfg, .q_valid, .q_ready, .q_item,
      .rsp_tvalid, .rsp_tready, .rsp_res(res)
   );

   assign rsp_tdata = {4'd0, res.search_diff, res.rom_id_out, res.data_out, res.status,
                       res.done, res.busy, res.line_drive};

endmodule

// ===== tb/one_wire_bus_master_with_rom_search_top_tb.sv =====
// testbench for the one-wire bus master: drives commands and bus ticks, predicts every
// result transaction and compares it field by field; depends on owm_pkg and the top level
module one_wire_bus_master_with_rom_search_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import owm_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;  // line_in, data_byte, rom_id, last_diff, use_address
   logic [2:0]  req_tuser = '0;  // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [87:0] rsp_tdata;       // line_drive, busy, done, status, data_out, rom_id_out, search_diff
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [9:0]  csr_data = '0;

   always #5 clock = ~clock;

   one_wire_bus_master_with_rom_search_top i_dut (.*);

   // bus master model state
   logic [9:0]  tim [7];
   phase_type   ph;
   kind_type    knd;
   logic [9:0]  tcnt;
   logic [6:0]  bpos, fdiff, sdiff;
   logic [7:0]  bsh, chold;
   logic [63:0] ish;
   logic        rbit, sbit, smp;
   logic [1:0]  err;
   logic [3:0]  bleft;
   logic [2:0]  opr;
   logic        fin;
   result_type  res_now;

   result_type  results_due [$];
   int          errors = 0;
   int          items_sent = 0;
   bit          calm = 1'b0;

   // line behavior chosen by the stimulus
   bit          noisy, pres_ok, tail_ok;
   logic        pair_a, pair_b;

   function automatic void finish_op(logic [1:0] st);
      ph = PH_IDLE;
      fin = 1'b1;
      res_now.status = st;
      if (opr == CMD_BYTE && st == ST_OK) res_now.data_out = bsh;
      if (opr == CMD_SEARCH && st == ST_OK) begin
         res_now.rom_id_out = ish;
         res_now.search_diff = fdiff;
      end
   endfunction

   function automatic void begin_slot(logic b, kind_type k);
      ph = PH_SLOT;
      tcnt = '0;
      sbit = b;
      knd = k;
      smp = 1'b0;
   endfunction

   function automatic void begin_byte(logic [7:0] v);
      bsh = v;
      bpos = 7'd8;
      begin_slot(v[0], K_BYTE);
   endfunction

   function automatic void byte_done();
      logic [7:0] v;
      if (opr == CMD_SEARCH) begin
         bpos = 7'd64;
         begin_slot(1'b1, K_READ);
      end else if (opr == CMD_ADDR) begin
         if (bleft == 0) finish_op(err);
         else if (bleft > 1) begin
            v = ish[7:0];
            ish = ish >> 8;
            bleft = bleft - 4'd1;
            begin_byte(v);
         end else begin
            bleft = 0;
            begin_byte(chold);
         end
      end else finish_op(ST_OK);
   endfunction

   function automatic void bit_done();
      logic b;
      case (knd)
         K_BYTE: begin
            bsh = {smp, bsh[7:1]};
            bpos = bpos - 7'd1;
            if (bpos == 0) byte_done();
            else begin_slot(bsh[0], K_BYTE);
         end
         K_READ: begin
            rbit = smp;
            begin_slot(1'b1, K_COMP);
         end
         K_COMP: begin
            b = rbit;
            if (b && smp) begin
               finish_op(ST_DATA);
               return;
            end
            // both values present: pick the branch and remember the discrepancy
            if (!b && !smp && (sdiff > bpos || (ish[0] && sdiff != bpos))) begin
               b = 1'b1;
               fdiff = bpos;
            end
            begin_slot(b, K_WRITE);
         end
         default: begin
            ish = {sbit, ish[63:1]};
            bpos = bpos - 7'd1;
            if (bpos == 0) finish_op(ST_OK);
            else begin_slot(1'b1, K_READ);
         end
      endcase
   endfunction

   function automatic void bus_tick(logic line);
      logic [10:0] tgt;
      logic [10:0] slot_end;
      if (ph == PH_IDLE) return;
      tcnt = tcnt + 10'd1;
      case (ph)
         PH_RST_LOW: if (tcnt >= at_least_one(tim[REG_RESET_LOW])) begin
            ph = PH_RST_WAIT;
            tcnt = '0;
         end
         PH_RST_WAIT: if (tcnt >= at_least_one(tim[REG_PRESENCE_WAIT])) begin
            err = {1'b0, line};
            ph = PH_RST_TAIL;
            tcnt = '0;
         end
         PH_RST_TAIL: if (tcnt >= at_least_one(tim[REG_RESET_TAIL])) begin
            if (!line) err = ST_NO_PRES;
            if (opr == CMD_RESET) finish_op(err);
            else if (opr == CMD_SEARCH) begin
               if (err != ST_OK) finish_op(ST_NO_PRES);
               else begin_byte(OW_SEARCH);
            end else begin_byte(bleft > 1 ? OW_MATCH : OW_SKIP);
         end
         PH_SLOT: begin
            tgt = tim[REG_RELEASE] + tim[REG_SAMPLE];
            if (tgt > tim[REG_SLOT]) tgt = tim[REG_SLOT];
            if (tgt == 0) tgt = 11'd1;
            slot_end = at_least_one(tim[REG_SLOT]);
            if (tcnt == tgt) smp = sbit & line;
            if (tcnt >= slot_end) begin
               if (tim[REG_GAP] == 0) bit_done();
               else begin
                  ph = PH_GAP;
                  tcnt = '0;
               end
            end
         end
         PH_GAP: if (tcnt >= tim[REG_GAP]) bit_done();
         default: ph = PH_IDLE;
      endcase
   endfunction

   function automatic result_type master_step(logic [2:0] cmd, logic line, logic [7:0] db,
                                              logic [63:0] id, logic [6:0] ld, logic ua);
      fin = 1'b0;
      res_now = '0;
      if (ph == PH_IDLE && cmd >= CMD_RESET && cmd <= CMD_ADDR) begin
         opr = cmd;
         err = ST_OK;
         tcnt = '0;
         if (cmd == CMD_BYTE) begin_byte(db);
         else begin
            ph = PH_RST_LOW;
            if (cmd == CMD_SEARCH) begin
               ish = id;
               sdiff = ld;
               fdiff = '0;
            end else if (cmd == CMD_ADDR) begin
               ish = id;
               chold = db;
               bleft = ua ? 4'(ROM_BYTES_DEF + 1) : 4'd1;
            end
         end
      end else bus_tick(line);
      if (ph == PH_RST_LOW) res_now.line_drive = 1'b1;
      else if (ph == PH_SLOT) res_now.line_drive = !(sbit && tcnt >= tim[REG_RELEASE]);
      res_now.busy = (ph != PH_IDLE);
      res_now.done = fin;
      return res_now;
   endfunction

   // one input transaction, with an optional gap before it
   task automatic send(logic [2:0] cmd, logic line, logic [7:0] db = '0,
                       logic [63:0] id = '0, logic [6:0] ld = '0, logic ua = 1'b0);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'd0, ua, ld, id, db, line};
      do @(posedge clock); while (!req_tready);
      results_due.push_back(master_step(cmd, line, db, id, ld, ua));
      items_sent++;
   endtask

   // bus level for the next tick, as a well-behaved bus or noise
   task automatic pick_line(output logic line);
      int r;
      line = 1'($urandom_range(0, 1));
      if (noisy) return;
      if (ph == PH_RST_WAIT) line = !pres_ok;
      else if (ph == PH_RST_TAIL) line = tail_ok;
      else if (ph == PH_SLOT && knd == K_READ) line = pair_a;
      else if (ph == PH_SLOT && knd == K_COMP) line = pair_b;
      else if (ph == PH_SLOT && knd == K_WRITE) begin
         r = $urandom_range(0, 255);
         if (r == 0) {pair_a, pair_b} = 2'b11;
         else if (r < 64) {pair_a, pair_b} = 2'b00;
         else begin
            pair_a = 1'($urandom_range(0, 1));
            pair_b = !pair_a;
         end
      end
   endtask

   // start one operation and tick the bus until it is over
   task automatic run_op(logic [2:0] cmd, logic [7:0] db, logic [63:0] id, logic [6:0] ld,
                         logic ua, bit chatty = 1'b0);
      logic line;
      logic [2:0] c;
      pair_a = 1'b1;
      pair_b = 1'b0;
      send(cmd, 1'b0, db, id, ld, ua);
      while (ph != PH_IDLE) begin
         pick_line(line);
         c = CMD_TICK;
         // a command while busy counts as a tick
         if (chatty && $urandom_range(0, 19) == 0) c = 3'($urandom_range(1, 7));
         send(c, line, 8'($urandom), {$urandom, $urandom}, 7'($urandom_range(0, 65)),
              1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [9:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tim[idx] = val;
   endtask

   task automatic set_timing(logic [9:0] rl, logic [9:0] pw, logic [9:0] rt, logic [9:0] rel,
                             logic [9:0] smpl, logic [9:0] slot, logic [9:0] gap);
      wait_drained();
      write_reg(REG_RESET_LOW, rl);
      write_reg(REG_PRESENCE_WAIT, pw);
      write_reg(REG_RESET_TAIL, rt);
      write_reg(REG_RELEASE, rel);
      write_reg(REG_SAMPLE, smpl);
      write_reg(REG_SLOT, slot);
      write_reg(REG_GAP, gap);
   endtask

   task automatic test_bus_reset();
      noisy = 0;
      pres_ok = 1; tail_ok = 1;
      run_op(CMD_RESET, '0, '0, '0, 0);
      pres_ok = 0;
      run_op(CMD_RESET, '0, '0, '0, 0);
      pres_ok = 1; tail_ok = 0;  // line stuck low
      run_op(CMD_RESET, '0, '0, '0, 0);
   endtask

   task automatic test_byte_exchange();
      noisy = 0;
      run_op(CMD_BYTE, 8'hA5, '0, '0, 0);  // power-on timing
      set_timing(3, 2, 2, 1, 1, 3, 1);
      run_op(CMD_BYTE, 8'hFF, '0, '0, 0);
      noisy = 1;
      run_op(CMD_BYTE, 8'h3C, '0, '0, 0);
   endtask

   task automatic test_addressed();
      set_timing(2, 1, 2, 1, 0, 1, 0);
      noisy = 0; pres_ok = 1; tail_ok = 1;
      run_op(CMD_ADDR, 8'hFF, 64'h0123_4567_89AB_CDEF, '0, 1);
      run_op(CMD_ADDR, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, '0, 0);
      pres_ok = 0;  // command still goes out after a failed reset
      run_op(CMD_ADDR, 8'h3C, 64'h0, '0, 0);
   endtask

   task automatic test_search();
      noisy = 0; pres_ok = 1; tail_ok = 1;
      run_op(CMD_SEARCH, '0, 64'h5555_AAAA_0F0F_F0F0, 7'd40, 0);
      pres_ok = 0;
      run_op(CMD_SEARCH, '0, '0, 7'd65, 0);
      noisy = 1; pres_ok = 1;  // random pairs, mostly aborted on a 11 pair
      run_op(CMD_SEARCH, '0, '0, 7'd33, 0);
   endtask

   task automatic test_odd_commands();
      send(CMD_TICK, 1'b0);
      send(CMD_TICK, 1'b1);
      send(3'd5, 1'b1);
      send(3'd6, 1'b0);
      send(3'd7, 1'b1);
      noisy = 1;
      run_op(CMD_BYTE, 8'h5A, '0, '0, 0, 1'b1);
   endtask

   task automatic test_extreme_timing();
      set_timing(0, 0, 0, 0, 0, 0, 0);
      noisy = 0; pres_ok = 1; tail_ok = 1;
      run_op(CMD_RESET, '0, '0, '0, 0);
      run_op(CMD_BYTE, 8'h96, '0, '0, 0);
      // sample point clamped to the slot end
      set_timing(3, 2, 2, 1023, 1023, 4, 2);
      run_op(CMD_RESET, '0, '0, '0, 0);
      noisy = 1;
      run_op(CMD_BYTE, 8'hC3, '0, '0, 0);
   endtask

   task automatic test_random(int n);
      int stop;
      logic [6:0] ld;
      stop = items_sent + n;
      while (items_sent < stop) begin
         noisy = ($urandom_range(0, 7) == 0);
         pres_ok = ($urandom_range(0, 9) != 0);
         tail_ok = ($urandom_range(0, 9) != 0);
         ld = ($urandom_range(0, 3) == 0) ? 7'd65 : 7'($urandom_range(0, 64));
         if ($urandom_range(0, 5) == 0)
            send($urandom_range(0, 1) ? CMD_TICK : 3'($urandom_range(5, 7)),
                 1'($urandom_range(0, 1)));
         else
            run_op(3'($urandom_range(1, 4)), 8'($urandom), {$urandom, $urandom}, ld,
                   1'($urandom_range(0, 1)), 1'b1);
      end
   endtask

   // result channel backpressure
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            $error("result transaction with nothing outstanding");
            errors++;
         end else begin
            want = results_due.pop_front();
            check_field("line_drive", want.line_drive, rsp_tdata[0]);
            check_field("busy_res", want.busy, rsp_tdata[1]);
            check_field("done_res", want.done, rsp_tdata[2]);
            check_field("status", want.status, rsp_tdata[4:3]);
            check_field("data_out", want.data_out, rsp_tdata[12:5]);
            check_field("rom_id_out", want.rom_id_out, rsp_tdata[76:13]);
            check_field("search_diff", want.search_diff, rsp_tdata[83:77]);
            check_field("padding", '0, rsp_tdata[87:84]);
         end
      end
   end

   initial begin
      #50ms;
      $display("one_wire_bus_master_with_rom_search_top_tb: errors");
      $finish;
   end

   initial begin
      tim[REG_RESET_LOW] = RESET_LOW_DEF;
      tim[REG_PRESENCE_WAIT] = PRESENCE_WAIT_DEF;
      tim[REG_RESET_TAIL] = RESET_TAIL_DEF;
      tim[REG_RELEASE] = RELEASE_DEF;
      tim[REG_SAMPLE] = SAMPLE_DEF;
      tim[REG_SLOT] = SLOT_DEF;
      tim[REG_GAP] = GAP_DEF;
      ph = PH_IDLE; knd = K_BYTE; tcnt = '0; bpos = '0; fdiff = '0; sdiff = '0;
      bsh = '0; chold = '0; ish = '0; rbit = 0; sbit = 0; smp = 0; err = '0;
      bleft = '0; opr = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_byte_exchange();
      test_bus_reset();
      test_addressed();
      test_search();
      test_odd_commands();
      test_extreme_timing();
      set_timing(2, 1, 1, 0, 1, 1, 0);
      test_random(40);
      calm = 1'b1;
      test_random(40);
      wait_drained();
      if (errors == 0)
         $display("one_wire_bus_master_with_rom_search_top_tb: clean");
      else
         $display("one_wire_bus_master_with_rom_search_top_tb: errors");
      $finish;
   end

endmodule
